// ===== rtl/nbts_pkg.sv =====
`timescale 1ns / 1ps
package nbts_pkg;

    localparam int unsigned STACK_DEPTH_DEFAULT = 16;

    // Kind of an open entry on the bracket stack
    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_QUOTE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ERROR    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    // One result item
    typedef struct packed {
        logic       append;
        logic [7:0] char_out;
        logic       consumed;
        logic       token_done;
        t_status    status;
    } t_result;

    // Stack update requested by the step logic
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        logic  quote_set;
        logic  quote_clr;
        t_kind kind;
    } t_stack_op;

endpackage

// ===== rtl/nbts_if.sv =====
`timescale 1ns / 1ps
interface nbts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

interface nbts_out_if;
    logic       valid;
    logic       ready;
    logic       append;
    logic [7:0] char_out;
    logic       consumed;
    logic       token_done;
    logic [1:0] status;

    modport source (output valid, output append, output char_out, output consumed,
                    output token_done, output status, input ready);
    modport sink   (input valid, input append, input char_out, input consumed,
                    input token_done, input status, output ready);
endinterface

// ===== rtl/nbts_ram.sv =====
`timescale 1ns / 1ps
module nbts_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/nbts_step.sv =====
`timescale 1ns / 1ps
module nbts_step (
    input  logic               i_end_of_input,
    input  logic [7:0]         i_char,
    input  logic               i_level_zero,
    input  logic               i_full,
    input  logic               i_in_quote,
    input  nbts_pkg::t_kind    i_top,
    output nbts_pkg::t_result  o_result,
    output nbts_pkg::t_stack_op o_op
);
    import nbts_pkg::*;

    logic  is_term;
    logic  is_opener;
    logic  is_closer;
    t_kind open_kind;
    t_kind want_kind;

    always_comb begin
        is_term = 1'b0;
        case (i_char) inside
            [CH_TAB:CH_CR], CH_SPACE, CH_SEMI, CH_COMMA, CH_RSQUARE: is_term = 1'b1;
            default: is_term = 1'b0;
        endcase
    end

    always_comb begin
        is_opener = 1'b1;
        open_kind = KIND_PAREN;
        case (i_char)
            CH_LPAREN:  open_kind = KIND_PAREN;
            CH_LSQUARE: open_kind = KIND_SQUARE;
            CH_LCURLY:  open_kind = KIND_CURLY;
            CH_QUOTE:   open_kind = KIND_QUOTE;
            default:    is_opener = 1'b0;
        endcase
    end

    always_comb begin
        is_closer = 1'b1;
        want_kind = KIND_PAREN;
        case (i_char)
            CH_RPAREN:  want_kind = KIND_PAREN;
            CH_RSQUARE: want_kind = KIND_SQUARE;
            CH_RCURLY:  want_kind = KIND_CURLY;
            default:    is_closer = 1'b0;
        endcase
    end

    always_comb begin
        o_result = '0;
        o_op     = '0;
        o_op.kind = open_kind;
        if (i_end_of_input) begin
            o_result.token_done = 1'b1;
            o_result.status = (!i_level_zero || i_in_quote) ? ST_ERROR : ST_OK;
        end else if (i_level_zero && !i_in_quote && is_term) begin
            o_result.token_done = 1'b1;
        end else begin
            o_result.consumed = 1'b1;
            o_result.append   = 1'b1;
            if (i_in_quote) begin
                if (i_char == CH_QUOTE) begin
                    o_op.quote_clr = 1'b1;
                    o_op.pop       = !i_level_zero;
                end
            end else if (is_opener) begin
                if (i_full) begin
                    // drop the opener and close the token
                    o_result.append     = 1'b0;
                    o_result.token_done = 1'b1;
                    o_result.status     = ST_OVERFLOW;
                end else begin
                    o_op.push      = 1'b1;
                    o_op.quote_set = (open_kind == KIND_QUOTE);
                end
            end else if (is_closer) begin
                if (i_level_zero) begin
                    o_result.append     = 1'b0;
                    o_result.token_done = 1'b1;
                end else if (i_top == want_kind) begin
                    o_op.pop = 1'b1;
                end else begin
                    o_result.token_done = 1'b1;
                    o_result.status     = ST_ERROR;
                end
            end
            o_result.char_out = o_result.append ? i_char : 8'h00;
        end
        o_op.clear = o_result.token_done;
    end

endmodule

// ===== rtl/nested_bracket_token_scanner.sv =====
`timescale 1ns / 1ps
// Bracket-aware token scanner.
// Input channel i_in carries one character (char_in) or an end-of-input marker
// per transfer. Output channel o_out returns exactly one result per input
// transfer: whether the character joins the token (append, char_out), whether
// it was consumed, and whether the token ends here with its status.
// A result is registered and valid the cycle after its input transfer. Throughput:
// one character per cycle while the receiver keeps up; the stack top is kept live
// by a registered RAM read issued for the level the current character leaves
// behind, with a bypass for the entry pushed in that same cycle.
// Reset clears the stack level, the quote flag, the bypass flag and the output
// valid flag; the stack RAM needs no clearing, as only entries below the level
// are read. When the receiver stalls, the pending result holds in the output
// register and the input channel stops taking characters until that result is
// taken; a new character is taken in the same cycle the held result leaves.
module nested_bracket_token_scanner #(
    parameter int unsigned STACK_DEPTH = nbts_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nbts_in_if.sink     i_in,
    nbts_out_if.source  o_out
);
    import nbts_pkg::*;

    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Stack level and quote flag
    logic [LW-1:0] r_level;
    logic [LW-1:0] n_level;
    logic          r_in_quote;
    logic          n_in_quote;

    // Bypass for the entry written in the previous cycle
    logic          r_fwd_vld;
    logic          n_fwd_vld;
    t_kind         r_fwd_kind;

    // Output register
    logic          r_out_valid;
    t_result       r_out;

    logic          accept;
    logic [1:0]    ram_rd_data;
    logic [LW-1:0] rd_level;
    t_kind         top_kind;
    t_result       step_result;
    t_stack_op     step_op;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // Top of stack: freshly pushed entry or the RAM's registered read
    assign top_kind = r_fwd_vld ? r_fwd_kind : t_kind'(ram_rd_data);

    nbts_step u_step (
        .i_end_of_input (i_in.end_of_input),
        .i_char         (i_in.char_in),
        .i_level_zero   (r_level == '0),
        .i_full         (r_level == LW'(STACK_DEPTH)),
        .i_in_quote     (r_in_quote),
        .i_top          (top_kind),
        .o_result       (step_result),
        .o_op           (step_op)
    );

    // Advance level and quote state on each transfer
    always_comb begin
        n_level    = r_level;
        n_in_quote = r_in_quote;
        n_fwd_vld  = 1'b0;
        if (accept) begin
            if (step_op.clear) begin
                n_level    = '0;
                n_in_quote = 1'b0;
            end else begin
                if (step_op.push) begin
                    n_level   = r_level + LW'(1);
                    n_fwd_vld = 1'b1;
                end else if (step_op.pop) begin
                    n_level = r_level - LW'(1);
                end
                if (step_op.quote_set) begin
                    n_in_quote = 1'b1;
                end else if (step_op.quote_clr) begin
                    n_in_quote = 1'b0;
                end
            end
        end
    end

    // Read the entry that will be on top next cycle
    assign rd_level = n_level - LW'(1);

    nbts_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (accept && step_op.push && !step_op.clear),
        .i_wr_addr (r_level[AW-1:0]),
        .i_wr_data (step_op.kind),
        .i_rd_addr (rd_level[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_in_quote  <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_level    <= n_level;
            r_in_quote <= n_in_quote;
            r_fwd_vld  <= n_fwd_vld;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the result holds until the next transfer; the bypass kind is captured every cycle
    always_ff @(posedge i_clk) begin
        r_fwd_kind <= step_op.kind;
        if (accept) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.append     = r_out.append;
    assign o_out.char_out   = r_out.char_out;
    assign o_out.consumed   = r_out.consumed;
    assign o_out.token_done = r_out.token_done;
    assign o_out.status     = r_out.status;

endmodule

// ===== bench/tb_nested_bracket_token_scanner.sv =====
`timescale 1ns / 1ps
module tb_nested_bracket_token_scanner;
    import nbts_pkg::*;

    localparam int unsigned STACK_DEPTH   = STACK_DEPTH_DEFAULT;
    localparam int          CHAR_TARGET   = 1330;     // directed plus about 1300 random
    localparam int          DRAIN_SPACING = 400;      // characters between full drains
    localparam time         RUN_LIMIT     = 2ms;

    // One character transfer waiting to be driven
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        logic       wait_idle;    // hold off until every result has come back
    } t_char_item;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE   = 2'd0,
        RX_RANDOM = 2'd1,
        RX_TOGGLE = 2'd2,
        RX_LONG   = 2'd3
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nbts_in_if  in_if ();
    nbts_out_if out_if ();

    nested_bracket_token_scanner #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_char_item char_q[$];
    t_result    token_q[$];       // predicted scanner results, oldest first
    logic       idle_next = 1'b0;
    logic       in_fired  = 1'b0;

    // Scanner state as the predictor sees it
    t_kind       open_kind [STACK_DEPTH];
    int unsigned open_depth = 0;
    logic        quote_open = 1'b0;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_tokens    = 0;
    int n_err_tok   = 0;
    int n_ovf_tok   = 0;
    int n_stalls    = 0;
    int n_fail      = 0;
    int next_drain  = DRAIN_SPACING;

    // ------------------------------------------------------------------
    // Predictor: advance the bracket stack by one character or end marker
    // and return the result the scanner must produce for it.
    // ------------------------------------------------------------------
    function automatic t_result scan_char(logic [7:0] ch, logic eoi);
        t_result r;
        t_kind   want;
        logic    is_ws;

        r      = '0;
        r.status = ST_OK;
        is_ws  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        if (eoi) begin
            // End of input: error only if something is still open
            r.token_done = 1'b1;
            r.status     = (open_depth != 0 || quote_open) ? ST_ERROR : ST_OK;
        end else if (open_depth == 0 && !quote_open &&
                     (is_ws || ch == CH_SEMI || ch == CH_COMMA || ch == CH_RSQUARE)) begin
            // Terminator at top level: leave it for the caller
            r.token_done = 1'b1;
        end else begin
            r.consumed = 1'b1;
            r.append   = 1'b1;
            if (quote_open) begin
                // Only a closing quote counts inside a quote
                if (ch == CH_QUOTE) begin
                    quote_open = 1'b0;
                    if (open_depth != 0)
                        open_depth--;
                end
            end else if (ch == CH_QUOTE || ch == CH_LPAREN || ch == CH_LSQUARE ||
                         ch == CH_LCURLY) begin
                if (open_depth >= STACK_DEPTH) begin
                    // Stack full: drop the opener and end with overflow
                    r.append     = 1'b0;
                    r.token_done = 1'b1;
                    r.status     = ST_OVERFLOW;
                end else begin
                    case (ch)
                        CH_QUOTE:   open_kind[open_depth] = KIND_QUOTE;
                        CH_LPAREN:  open_kind[open_depth] = KIND_PAREN;
                        CH_LSQUARE: open_kind[open_depth] = KIND_SQUARE;
                        default:    open_kind[open_depth] = KIND_CURLY;
                    endcase
                    open_depth++;
                    if (ch == CH_QUOTE)
                        quote_open = 1'b1;
                end
            end else if (ch == CH_RPAREN || ch == CH_RSQUARE || ch == CH_RCURLY) begin
                want = (ch == CH_RPAREN) ? KIND_PAREN :
                       (ch == CH_RSQUARE) ? KIND_SQUARE : KIND_CURLY;
                if (open_depth == 0) begin
                    // Stray closer: consumed, dropped, token ends cleanly
                    r.append     = 1'b0;
                    r.token_done = 1'b1;
                end else if (open_kind[open_depth - 1] == want) begin
                    open_depth--;
                end else begin
                    // Wrong closer: keep it, end with error
                    r.token_done = 1'b1;
                    r.status     = ST_ERROR;
                end
            end
            if (r.append)
                r.char_out = ch;
        end
        if (r.token_done) begin
            open_depth = 0;
            quote_open = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_char(logic [7:0] ch, logic eoi = 1'b0);
        t_char_item it;

        it.ch        = ch;
        it.eoi       = eoi;
        it.wait_idle = idle_next;
        idle_next    = 1'b0;
        char_q.push_back(it);
    endtask

    function automatic logic [7:0] opener_of(t_kind k);
        case (k)
            KIND_PAREN:  return CH_LPAREN;
            KIND_SQUARE: return CH_LSQUARE;
            KIND_CURLY:  return CH_LCURLY;
            default:     return CH_QUOTE;
        endcase
    endfunction

    function automatic logic [7:0] closer_of(t_kind k);
        case (k)
            KIND_PAREN:  return CH_RPAREN;
            KIND_SQUARE: return CH_RSQUARE;
            KIND_CURLY:  return CH_RCURLY;
            default:     return CH_QUOTE;
        endcase
    endfunction

    // Random byte with no meaning to the scanner
    function automatic logic [7:0] text_byte();
        logic [7:0] c;

        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_SEMI ||
                   c == CH_COMMA || c == CH_QUOTE || c == CH_LPAREN || c == CH_RPAREN ||
                   c == CH_LSQUARE || c == CH_RSQUARE || c == CH_LCURLY || c == CH_RCURLY);
        return c;
    endfunction

    // Queue one token: mostly well-formed nesting with random content, some deep
    // nesting up to and past the stack size, some broken endings and raw noise.
    task automatic gen_token(bit force_ovf);
        t_kind      gk[$];
        t_kind      k;
        int         pick, depth_cap, n, sel;
        bit         broken;
        logic [7:0] c;

        pick   = force_ovf ? 0 : $urandom_range(0, 99);
        broken = (pick >= 75);
        if (pick >= 88) begin
            // Raw noise, any byte value
            repeat ($urandom_range(1, 8))
                add_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) == 0)
                add_char(8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        if (pick < 12) begin
            // Deep nesting; one past the stack size overflows
            n = force_ovf ? STACK_DEPTH + 1 : $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 1);
            for (int i = 0; i < n; i++) begin
                if (i == STACK_DEPTH) begin
                    add_char(opener_of(t_kind'($urandom_range(0, 3))));
                end else begin
                    k = t_kind'($urandom_range(0, 2));
                    gk.push_back(k);
                    add_char(opener_of(k));
                end
            end
            if (n > STACK_DEPTH)
                return;
        end else begin
            depth_cap = $urandom_range(1, 6);
            repeat ($urandom_range(1, 20)) begin
                sel = $urandom_range(0, 9);
                if (sel < 3 && gk.size() < depth_cap) begin
                    k = t_kind'($urandom_range(0, 3));
                    add_char(opener_of(k));
                    if (k == KIND_QUOTE) begin
                        // Quoted text: anything but the quote itself
                        repeat ($urandom_range(0, 4)) begin
                            do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
                            add_char(c);
                        end
                        add_char(CH_QUOTE);
                    end else begin
                        gk.push_back(k);
                    end
                end else if (sel < 6 && gk.size() != 0) begin
                    add_char(closer_of(gk.pop_back()));
                end else begin
                    add_char(text_byte());
                end
            end
        end

        if (broken && gk.size() != 0) begin
            case ($urandom_range(0, 2))
                0: add_char(closer_of(t_kind'((int'(gk[$]) + $urandom_range(1, 2)) % 3)));
                1: add_char(8'($urandom_range(0, 255)), 1'b1);
                default: begin
                    repeat ($urandom_range(1, 6))
                        add_char(8'($urandom_range(0, 255)));
                    add_char(8'($urandom_range(0, 255)), 1'b1);
                end
            endcase
        end else begin
            while (gk.size() != 0)
                add_char(closer_of(gk.pop_back()));
            sel = $urandom_range(0, 11);
            case (sel)
                5:       add_char(CH_SPACE);
                6:       add_char(CH_SEMI);
                7:       add_char(CH_COMMA);
                8:       add_char(CH_RSQUARE);
                9:       add_char(CH_RPAREN);
                10:      add_char(CH_RCURLY);
                11:      add_char(8'($urandom_range(0, 255)), 1'b1);
                default: add_char(8'(CH_TAB + sel));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps, changes at negedge
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.char_in      <= 8'h00;
            in_if.end_of_input <= 1'b0;
            burst_left         <= 0;
            gap_left           <= 0;
        end else begin
            if (in_fired)
                void'(char_q.pop_front());
            // Only pick a new character once the slot is free
            if (in_fired || !in_if.valid) begin
                if (gap_left != 0) begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end else if (char_q.size() == 0 ||
                             (char_q[0].wait_idle && token_q.size() != 0)) begin
                    in_if.valid <= 1'b0;
                end else begin
                    in_if.valid        <= 1'b1;
                    in_if.char_in      <= char_q[0].ch;
                    in_if.end_of_input <= char_q[0].eoi;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: a random stall pattern, held for a random window of cycles
    // ------------------------------------------------------------------
    t_stall_mode stall_mode = RX_FREE;
    int          stall_win  = 0;
    int          stall_cnt  = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_mode   <= RX_FREE;
            stall_win    <= 0;
            stall_cnt    <= 0;
        end else begin
            if (stall_win == 0) begin
                stall_mode <= t_stall_mode'($urandom_range(0, 3));
                stall_win  <= $urandom_range(20, 80);
            end else begin
                stall_win <= stall_win - 1;
            end
            case (stall_mode)
                RX_FREE:   out_if.ready <= 1'b1;
                RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: out_if.ready <= ~out_if.ready;
                default: begin
                    if (stall_cnt == 0) begin
                        out_if.ready <= ~out_if.ready;
                        stall_cnt    <= $urandom_range(1, 8);
                    end else begin
                        stall_cnt <= stall_cnt - 1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each result transfer, then predict each accepted character
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result got;

        if (!i_rst_n) begin
            in_fired   <= 1'b0;
            open_depth = 0;
            quote_open = 1'b0;
        end else begin
            if (out_if.valid && !out_if.ready)
                n_stalls++;
            if (out_if.valid && out_if.ready) begin
                n_results++;
                got.append     = out_if.append;
                got.char_out   = out_if.char_out;
                got.consumed   = out_if.consumed;
                got.token_done = out_if.token_done;
                got.status     = t_status'(out_if.status);
                if (token_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: unexpected result app=%b ch=%h con=%b done=%b st=%0d",
                                 $realtime, got.append, got.char_out, got.consumed,
                                 got.token_done, got.status);
                end else begin
                    want = token_q.pop_front();
                    if (want.token_done) begin
                        n_tokens++;
                        if (want.status == ST_ERROR)
                            n_err_tok++;
                        if (want.status == ST_OVERFLOW)
                            n_ovf_tok++;
                    end
                    if (got.append !== want.append || got.char_out !== want.char_out ||
                        got.consumed !== want.consumed || got.token_done !== want.token_done ||
                        got.status !== want.status) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: result %0d mismatch", $realtime, n_results);
                            $display("    expected app=%b ch=%h con=%b done=%b st=%0d",
                                     want.append, want.char_out, want.consumed,
                                     want.token_done, want.status);
                            $display("    got      app=%b ch=%h con=%b done=%b st=%0d",
                                     got.append, got.char_out, got.consumed,
                                     got.token_done, got.status);
                        end
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                n_accepted++;
                token_q.push_back(scan_char(in_if.char_in, in_if.end_of_input));
            end
            in_fired <= in_if.valid && in_if.ready;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : run
        in_if.valid        = 1'b0;
        in_if.char_in      = 8'h00;
        in_if.end_of_input = 1'b0;
        out_if.ready       = 1'b0;

        // Empty token, byte extremes, top-level terminators, stray closers
        add_char(8'hFF, 1'b1);
        add_char(8'h00);
        add_char(8'hFF);
        add_char(8'h00, 1'b1);
        add_char(CH_SPACE);
        add_char(CH_TAB);
        add_char(CH_CR);
        add_char(CH_SEMI);
        add_char(CH_COMMA);
        add_char(CH_RSQUARE);
        add_char(CH_RPAREN);
        add_char(CH_RCURLY);
        // All opener kinds, a closer hidden in a quote, matched unwinding
        add_char(CH_LPAREN);
        add_char(CH_LSQUARE);
        add_char(CH_LCURLY);
        add_char(CH_QUOTE);
        add_char(CH_RSQUARE);
        add_char(CH_QUOTE);
        add_char(CH_RCURLY);
        add_char(CH_RSQUARE);
        add_char(CH_RPAREN);
        add_char(8'h00, 1'b1);
        // Mismatched closer, then an unclosed quote at end of input
        add_char(CH_LPAREN);
        add_char(CH_RSQUARE);
        add_char(CH_QUOTE);
        add_char(8'h00, 1'b1);

        // Drain completely once before the random part, which opens with overflow
        idle_next = 1'b1;
        gen_token(1'b1);
        while (char_q.size() < CHAR_TARGET) begin
            if (char_q.size() >= next_drain) begin
                idle_next  = 1'b1;
                next_drain += DRAIN_SPACING;
            end
            gen_token(1'b0);
        end
        n_queued = char_q.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted != n_queued)
            @(posedge i_clk);
        while (token_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Scanned %0d characters into %0d tokens (%0d bracket errors, %0d overflows).",
                 n_accepted, n_tokens, n_err_tok, n_ovf_tok);
        $display("Checked %0d results with %0d receiver stall cycles; %0d failures.",
                 n_results, n_stalls, n_fail);
        if (n_fail == 0)
            $display("tb_nested_bracket_token_scanner: PASS");
        else
            $display("tb_nested_bracket_token_scanner: FAIL");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("Timeout: %0d of %0d characters accepted, %0d results outstanding.",
                 n_accepted, n_queued, token_q.size());
        $display("tb_nested_bracket_token_scanner: FAIL");
        $finish;
    end

endmodule
